@@ hw/rtl/indexed_list_table_defines.svh @@
// Assertion macros used by ilt_ctrl, the one RTL file that carries checks.
// Every check is clocked on clk and disabled while rst is high.
`ifndef INDEXED_LIST_TABLE_DEFINES_SVH
`define INDEXED_LIST_TABLE_DEFINES_SVH

// Property must hold at every clock edge.
`define ILT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("indexed_list_table: property violated");

// Condition must never be true at a clock edge.
`define ILT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("indexed_list_table: forbidden condition seen");

`endif

@@ hw/rtl/ilt_pkg.sv @@
package ilt_pkg;

  // Store geometry
  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;

  // Entry index, entry count, and a compare width that also holds a position
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = 6;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Field widths of the stream beats
  localparam int OPC_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STS_W  = 2;
  localparam int RIDX_W = 6;
  localparam int ECNT_W = 7;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 3'd0,
    OP_SET    = 3'd1,
    OP_GET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_FIND   = 3'd4,
    OP_CLEAR  = 3'd5
  } opcode_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET,
    S_SHIFT,
    S_SCAN,
    S_RESP
  } state_t;

  // One result, as handed from the sequencer to the output register
  typedef struct packed {
    status_t             status;
    logic [RIDX_W-1:0]   result_index;
    logic [VAL_W-1:0]    read_value;
    logic [ECNT_W-1:0]   entry_count;
  } result_t;

  // Memory access issued by the sequencer
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

endpackage

@@ hw/rtl/ilt_ram.sv @@
module ilt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/ilt_ctrl.sv @@
`include "indexed_list_table_defines.svh"

module ilt_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ilt_pkg::OPC_W-1:0]     in_opcode,
  input  logic [ilt_pkg::POS_W-1:0]     in_position,
  input  logic [ilt_pkg::VAL_W-1:0]     in_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ilt_pkg::result_t              res,
  output ilt_pkg::ram_req_t             ram_req,
  input  logic [ilt_pkg::ITEM_WIDTH-1:0] ram_rdata
);

  import ilt_pkg::*;

  state_t                state, state_next;
  logic [OPC_W-1:0]      op;
  logic [CMP_W-1:0]      pos;
  logic [ITEM_WIDTH-1:0] val;
  logic [IDX_W-1:0]      ptr, ptr_next;
  logic [CNT_W-1:0]      count, count_next;
  result_t               res_next;

  logic [IDX_W-1:0]      pos_idx;
  logic [CNT_W-1:0]      pos_inc;
  logic [CNT_W-1:0]      ptr_inc;
  logic                  pos_ok;

  assign pos_idx = pos[IDX_W-1:0];
  assign pos_inc = CNT_W'(pos_idx) + 1'b1;
  assign ptr_inc = CNT_W'(ptr) + 1'b1;
  assign pos_ok  = pos < CMP_W'(count);

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Command, walk and result registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= in_opcode;
      pos <= CMP_W'(in_position);
      val <= ITEM_WIDTH'(in_item);
    end
    ptr <= ptr_next;
    res <= res_next;
  end

  // Sequencer: execute, then for remove and find walk the memory one entry per cycle
  always_comb begin
    state_next    = state;
    count_next    = count;
    ptr_next      = ptr;
    res_next      = res;
    ram_req       = '0;
    ram_req.wdata = val;
    in_ready      = 1'b0;
    res_valid     = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_next   = '{status: ST_OK, result_index: '0, read_value: '0,
                       entry_count: '0};
        state_next = S_RESP;
        unique case (op)
          OP_APPEND: begin
            if (count >= CNT_W'(CAPACITY)) begin
              res_next.status = ST_FULL;
            end else begin
              ram_req.we            = 1'b1;
              ram_req.waddr         = count[IDX_W-1:0];
              res_next.result_index = RIDX_W'(count);
              count_next            = count + 1'b1;
            end
          end
          OP_SET: begin
            if (!pos_ok) begin
              res_next.status = ST_RANGE;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.waddr = pos_idx;
            end
          end
          OP_GET: begin
            if (!pos_ok) begin
              res_next.status = ST_RANGE;
            end else begin
              ram_req.re    = 1'b1;
              ram_req.raddr = pos_idx;
              state_next    = S_GET;
            end
          end
          OP_REMOVE: begin
            if (!pos_ok) begin
              res_next.status = ST_RANGE;
            end else if (pos_inc < count) begin
              ram_req.re    = 1'b1;
              ram_req.raddr = pos_inc[IDX_W-1:0];
              ptr_next      = pos_inc[IDX_W-1:0];
              state_next    = S_SHIFT;
            end else begin
              // removing the last entry: nothing to move
              count_next = count - 1'b1;
            end
          end
          OP_FIND: begin
            if (count == '0) begin
              res_next.status = ST_NOTFOUND;
            end else begin
              ram_req.re    = 1'b1;
              ram_req.raddr = '0;
              ptr_next      = '0;
              state_next    = S_SCAN;
            end
          end
          OP_CLEAR: begin
            count_next = '0;
          end
          default: begin
            // unused opcodes leave the store and count as they are
          end
        endcase
      end

      S_GET: begin
        res_next.read_value = VAL_W'(ram_rdata);
        state_next          = S_RESP;
      end

      S_SHIFT: begin
        // entry at ptr moves down one place
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr - 1'b1;
        ram_req.wdata = ram_rdata;
        if (ptr_inc < count) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_inc[IDX_W-1:0];
          ptr_next      = ptr_inc[IDX_W-1:0];
        end else begin
          count_next = count - 1'b1;
          state_next = S_RESP;
        end
      end

      S_SCAN: begin
        if (ram_rdata == val) begin
          res_next.result_index = RIDX_W'(ptr);
          state_next            = S_RESP;
        end else if (ptr_inc < count) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_inc[IDX_W-1:0];
          ptr_next      = ptr_inc[IDX_W-1:0];
        end else begin
          res_next.status = ST_NOTFOUND;
          state_next      = S_RESP;
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.entry_count = ECNT_W'(count_next);
  end

  // Checks
  `ILT_ASSERT(a_count_cap, count <= CNT_W'(CAPACITY))
  `ILT_ASSERT_NEVER(a_rw_collide, ram_req.we && ram_req.re && ram_req.waddr == ram_req.raddr)
  `ILT_ASSERT(a_count_at_resp, !$stable(count) |-> state == S_RESP)
  `ILT_ASSERT(a_data_requested, (state == S_GET || state == S_SHIFT || state == S_SCAN) |-> $past(ram_req.re))

endmodule

@@ hw/rtl/indexed_list_table.sv @@
// Packed list store of CAPACITY entries held in a single-port-write,
// registered-read memory, driven by one command beat at a time. Each command
// on the s_ stream gives exactly one result beat on the m_ stream. Append,
// set, clear, unused opcodes and out-of-range or full cases go from
// acceptance through the execute state to the response state; get adds a
// state that captures the memory read. Remove walks the memory one entry per
// cycle to close the gap, moving each later entry down one place. Find scans
// from index 0 one entry per cycle and stops at the first match. Both walk
// rates come from the one memory read port stepping one entry each cycle. A new
// command is taken once the previous result sits in the output register,
// even if the downstream side has not taken it yet. Entries are not cleared
// at reset; only entries below the count are ever read.
module indexed_list_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: opcode[2:0], position[8:3], item_value[40:9], zero[47:41]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: status[1:0], result_index[7:2], read_value[39:8],
  //          entry_count[46:40], zero[47]
  output logic [47:0] m_tdata
);

  import ilt_pkg::*;

  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  ram_req_t              ram_req;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  ilt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_opcode  (s_tdata[2:0]),
    .in_position(s_tdata[8:3]),
    .in_item    (s_tdata[40:9]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  ilt_ram #(
    .WIDTH(ITEM_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .re   (ram_req.re),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  // Output register: loads when empty or when the waiting beat is taken
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, res.entry_count, res.read_value, res.result_index, res.status};
    end
  end

endmodule
